/* hw/rtl/gha_pkg.sv */
`timescale 1ns / 1ps

package gha_pkg;

   localparam int MAX_FEATURES_DEF   = 256;
   localparam int MAX_BINS_DEF       = 4096;
   localparam int BIN_INDEX_BITS_DEF = 8;

   typedef enum logic [1:0] {
      OP_WRITE_OFFSET = 2'd0,
      OP_ACCUMULATE   = 2'd1,
      OP_READ         = 2'd2,
      OP_READ_CLEAR   = 2'd3
   } opcode_type;

   typedef enum logic {
      CSR_FEATURE_COUNT = 1'b0,
      CSR_TOTAL_BINS    = 1'b1
   } csr_index_type;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

endpackage

/* hw/rtl/gha_offset_table.sv */
`timescale 1ns / 1ps

module gha_offset_table #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [11:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [11:0]   wr_data
);

   logic [11:0]      mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [11:0]      rd_ofs_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ofs_ff <= mem[rd_addr];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_ofs_ff : 12'd0;

endmodule

/* hw/rtl/gha_bin_store.sv */
`timescale 1ns / 1ps

module gha_bin_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic signed [63:0] rd_grad,
   output logic signed [63:0] rd_hess,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic signed [63:0] wr_grad,
   input  logic signed [63:0] wr_hess
);

   logic [127:0] mem [DEPTH];
   logic [127:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_grad, wr_hess};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_grad = rd_ff[127:64];
   assign rd_hess = rd_ff[63:0];

endmodule

/* hw/rtl/gradient_histogram_accumulator_top.sv */
`timescale 1ns / 1ps
// Channel  Ports                                      Handshake
// req      req_opcode .. req_hess_in                  start & !busy
// rsp      rsp_grad_sum, rsp_hess_sum, rsp_status     rsp_valid, one cycle
// csr      csr_index, csr_wdata                       csr_we, no wait
//
// Offset writes and out-of-range items hold busy through LOOKUP (offset table
// read); in-range accumulates and reads go on to FETCH (bin memory read, then
// write-back for accumulates and read-clears). A result, if any, is registered
// from LOOKUP or FETCH. After reset a clearing pass zeroes the bin memory with
// busy high; csr writes are taken throughout. The receiver cannot stall rsp.

module gradient_histogram_accumulator_top #(
   parameter int MAX_FEATURES   = gha_pkg::MAX_FEATURES_DEF,
   parameter int MAX_BINS       = gha_pkg::MAX_BINS_DEF,
   parameter int BIN_INDEX_BITS = gha_pkg::BIN_INDEX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [7:0]         req_feature,
   input  logic [7:0]         req_local_bin,
   input  logic [11:0]        req_offset_value,
   input  logic [11:0]        req_read_bin,
   input  logic signed [31:0] req_grad_in,
   input  logic signed [31:0] req_hess_in,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_grad_sum,
   output logic signed [63:0] rsp_hess_sum,
   output logic               rsp_status,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [12:0]        csr_wdata
);

   localparam int FEAT_DEPTH = (MAX_FEATURES < 256) ? MAX_FEATURES : 256;
   localparam int FEAT_AW    = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
   localparam int BIN_AW     = $clog2(MAX_BINS);
   localparam logic [7:0] LBIN_MASK = 8'((32'd1 << BIN_INDEX_BITS) - 32'd1);
   localparam logic [BIN_AW-1:0] CLR_LAST = BIN_AW'(MAX_BINS - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CLEAR  = 4'b0010,
      ST_LOOKUP = 4'b0100,
      ST_FETCH  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [BIN_AW-1:0]   clr_ff, clr_in;
   logic [8:0]          feature_count_ff;
   logic [12:0]         total_bins_ff;

   gha_pkg::opcode_type op_ff;
   logic [7:0]          feature_ff;
   logic [7:0]          local_bin_ff;
   logic [11:0]         offset_value_ff;
   logic [11:0]         read_bin_ff;
   logic signed [31:0]  grad_ff;
   logic signed [31:0]  hess_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic signed [63:0]  rsp_grad_ff, rsp_grad_in;
   logic signed [63:0]  rsp_hess_ff, rsp_hess_in;

   logic                accept;
   logic [11:0]         ofs_rd;
   logic                ofs_we;
   logic                feat_ok;
   logic [12:0]         glob_bin;
   logic [12:0]         bin_sel;
   logic                bin_ok;
   logic [BIN_AW-1:0]   bin_addr;
   logic                bin_re;
   logic                bin_we;
   logic [BIN_AW-1:0]   bin_waddr;
   logic signed [63:0]  bin_wgrad, bin_whess;
   logic signed [63:0]  bin_rgrad, bin_rhess;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         feature_count_ff <= 9'd256;
         total_bins_ff    <= 13'd4096;
      end else if (csr_we) begin
         unique case (gha_pkg::csr_index_type'(csr_index))
            gha_pkg::CSR_FEATURE_COUNT: feature_count_ff <= csr_wdata[8:0];
            gha_pkg::CSR_TOTAL_BINS:    total_bins_ff    <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff           <= gha_pkg::opcode_type'(req_opcode);
         feature_ff      <= req_feature;
         local_bin_ff    <= req_local_bin & LBIN_MASK;
         offset_value_ff <= req_offset_value;
         read_bin_ff     <= req_read_bin;
         grad_ff         <= req_grad_in;
         hess_ff         <= req_hess_in;
      end
   end

   gha_offset_table #(
      .DEPTH (FEAT_DEPTH),
      .AW    (FEAT_AW)
   ) u_ofs (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (FEAT_AW'(req_feature)),
      .rd_data (ofs_rd),
      .wr_en   (ofs_we),
      .wr_addr (FEAT_AW'(feature_ff)),
      .wr_data (offset_value_ff)
   );

   gha_bin_store #(
      .DEPTH (MAX_BINS),
      .AW    (BIN_AW)
   ) u_bins (
      .clock   (clock),
      .rd_en   (bin_re),
      .rd_addr (bin_addr),
      .rd_grad (bin_rgrad),
      .rd_hess (bin_rhess),
      .wr_en   (bin_we),
      .wr_addr (bin_waddr),
      .wr_grad (bin_wgrad),
      .wr_hess (bin_whess)
   );

   // ofs_rd and the captured fields hold from LOOKUP through FETCH
   always_comb begin
      feat_ok  = ({1'b0, feature_ff} < feature_count_ff) && (32'(feature_ff) < MAX_FEATURES);
      glob_bin = {1'b0, ofs_rd} + {5'd0, local_bin_ff};
      bin_sel  = (op_ff == gha_pkg::OP_ACCUMULATE) ? glob_bin : {1'b0, read_bin_ff};
      bin_ok   = (bin_sel < total_bins_ff) && (32'(bin_sel) < MAX_BINS);
      bin_addr = BIN_AW'(bin_sel);
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ofs_we        = 1'b0;
      bin_re        = 1'b0;
      bin_we        = 1'b0;
      bin_waddr     = bin_addr;
      bin_wgrad     = 64'sd0;
      bin_whess     = 64'sd0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = gha_pkg::STATUS_OK;
      rsp_grad_in   = 64'sd0;
      rsp_hess_in   = 64'sd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_CLEAR: begin
            bin_we    = 1'b1;
            bin_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
            unique case (op_ff)
               gha_pkg::OP_WRITE_OFFSET: begin
                  ofs_we       = feat_ok;
                  rsp_valid_in = !feat_ok;
               end
               gha_pkg::OP_ACCUMULATE: begin
                  if (feat_ok && bin_ok) begin
                     bin_re   = 1'b1;
                     state_in = ST_FETCH;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
               gha_pkg::OP_READ, gha_pkg::OP_READ_CLEAR: begin
                  if (bin_ok) begin
                     bin_re   = 1'b1;
                     state_in = ST_FETCH;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
            endcase
            rsp_status_in = gha_pkg::STATUS_RANGE;
         end
         ST_FETCH: begin
            state_in = ST_IDLE;
            unique case (op_ff)
               gha_pkg::OP_ACCUMULATE: begin
                  bin_we    = 1'b1;
                  bin_wgrad = bin_rgrad + {{32{grad_ff[31]}}, grad_ff};
                  bin_whess = bin_rhess + {{32{hess_ff[31]}}, hess_ff};
               end
               gha_pkg::OP_READ_CLEAR: begin
                  bin_we       = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_grad_in  = bin_rgrad;
                  rsp_hess_in  = bin_rhess;
               end
               gha_pkg::OP_READ: begin
                  rsp_valid_in = 1'b1;
                  rsp_grad_in  = bin_rgrad;
                  rsp_hess_in  = bin_rhess;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_grad_ff   <= rsp_grad_in;
      rsp_hess_ff   <= rsp_hess_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_grad_sum = rsp_grad_ff;
   assign rsp_hess_sum = rsp_hess_ff;

endmodule

/* hw/rtl/gha_checker.sv */
`timescale 1ns / 1ps

module gha_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_opcode,
   input logic               rsp_valid,
   input logic               rsp_status,
   input logic signed [63:0] rsp_grad_sum,
   input logic signed [63:0] rsp_hess_sum
);

   // every result beat follows a cycle with an item in flight
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without an item in flight");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after accept");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result beats in a row");

   a_offset_write_no_ok: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == gha_pkg::OP_WRITE_OFFSET)
         |=> ##1 (!rsp_valid || rsp_status == gha_pkg::STATUS_RANGE))
      else $error("offset write returned an ok beat");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == gha_pkg::STATUS_RANGE)
         |-> (rsp_grad_sum == 64'sd0 && rsp_hess_sum == 64'sd0))
      else $error("error beat with nonzero sums");

endmodule

bind gradient_histogram_accumulator_top gha_checker u_gha_checker (.*);

/* dv/bin_sum_checker.sv */
`timescale 1ns / 1ps

module bin_sum_checker #(
   parameter int MAX_FEATURES   = gha_pkg::MAX_FEATURES_DEF,
   parameter int MAX_BINS       = gha_pkg::MAX_BINS_DEF,
   parameter int BIN_INDEX_BITS = gha_pkg::BIN_INDEX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [7:0]         req_feature,
   input  logic [7:0]         req_local_bin,
   input  logic [11:0]        req_offset_value,
   input  logic [11:0]        req_read_bin,
   input  logic signed [31:0] req_grad_in,
   input  logic signed [31:0] req_hess_in,
   input  logic               rsp_valid,
   input  logic signed [63:0] rsp_grad_sum,
   input  logic signed [63:0] rsp_hess_sum,
   input  logic               rsp_status,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [12:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic [63:0] grad;
      logic [63:0] hess;
      logic        status;
   } bin_readout_type;

   bin_readout_type readout_q[$];
   logic [11:0]     offset_table [MAX_FEATURES];
   logic [63:0]     grad_acc [MAX_BINS];
   logic [63:0]     hess_acc [MAX_BINS];
   logic [8:0]      feature_limit;
   logic [12:0]     bin_limit;
   int              errs;

   function automatic logic feature_valid(input logic [7:0] f);
      return (int'(f) < int'(feature_limit)) && (int'(f) < MAX_FEATURES);
   endfunction

   function automatic logic bin_valid(input int b);
      return (b < int'(bin_limit)) && (b < MAX_BINS);
   endfunction

   // Updates the shadow histogram and queues the readout this beat produces, if any.
   function automatic void apply_item(input gha_pkg::opcode_type op, input logic [7:0] feat,
                                      input logic [7:0] lbin, input logic [11:0] offv,
                                      input logic [11:0] rbin, input logic [31:0] g,
                                      input logic [31:0] h);
      int              gbin;
      bin_readout_type r;
      r.grad   = '0;
      r.hess   = '0;
      r.status = gha_pkg::STATUS_RANGE;
      case (op)
         gha_pkg::OP_WRITE_OFFSET: begin
            if (feature_valid(feat)) offset_table[feat] = offv;
            else readout_q = {readout_q, r};
         end
         gha_pkg::OP_ACCUMULATE: begin
            gbin = int'(offset_table[feat]) + (int'(lbin) & ((1 << BIN_INDEX_BITS) - 1));
            if (!feature_valid(feat) || !bin_valid(gbin)) begin
               readout_q = {readout_q, r};
            end else begin
               grad_acc[gbin] = grad_acc[gbin] + {{32{g[31]}}, g};
               hess_acc[gbin] = hess_acc[gbin] + {{32{h[31]}}, h};
            end
         end
         default: begin
            if (!bin_valid(int'(rbin))) begin
               readout_q = {readout_q, r};
            end else begin
               r.grad   = grad_acc[rbin];
               r.hess   = hess_acc[rbin];
               r.status = gha_pkg::STATUS_OK;
               readout_q = {readout_q, r};
               if (op == gha_pkg::OP_READ_CLEAR) begin
                  grad_acc[rbin] = '0;
                  hess_acc[rbin] = '0;
               end
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      bin_readout_type want;
      if (reset) begin
         readout_q.delete();
         feature_limit = 9'd256;
         bin_limit     = 13'd4096;
         for (int i = 0; i < MAX_FEATURES; i++) offset_table[i] = '0;
         for (int i = 0; i < MAX_BINS; i++) begin
            grad_acc[i] = '0;
            hess_acc[i] = '0;
         end
      end else begin
         // result beats belong to earlier accepts, so pop before pushing this edge's item
         if (rsp_valid) begin
            if (readout_q.size() == 0) begin
               $error("unexpected result beat: grad_sum %0d hess_sum %0d status %0d",
                      rsp_grad_sum, rsp_hess_sum, rsp_status);
               errs++;
            end else begin
               want = readout_q.pop_front();
               if (rsp_grad_sum !== want.grad) begin
                  $error("grad_sum mismatch: expected %0d, actual %0d",
                         $signed(want.grad), rsp_grad_sum);
                  errs++;
               end
               if (rsp_hess_sum !== want.hess) begin
                  $error("hess_sum mismatch: expected %0d, actual %0d",
                         $signed(want.hess), rsp_hess_sum);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
                  errs++;
               end
            end
         end
         if (start && !busy)
            apply_item(gha_pkg::opcode_type'(req_opcode), req_feature, req_local_bin,
                       req_offset_value, req_read_bin, req_grad_in, req_hess_in);
         if (csr_we) begin
            case (gha_pkg::csr_index_type'(csr_index))
               gha_pkg::CSR_FEATURE_COUNT: feature_limit = csr_wdata[8:0];
               gha_pkg::CSR_TOTAL_BINS:    bin_limit = csr_wdata;
               default: ;
            endcase
         end
      end
      pending    <= readout_q.size();
      fail_count <= errs;
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int NUM_PHASES     = 6;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   gha_pkg::opcode_type    req_opcode = gha_pkg::OP_READ;
   logic [7:0]             req_feature = '0;
   logic [7:0]             req_local_bin = '0;
   logic [11:0]            req_offset_value = '0;
   logic [11:0]            req_read_bin = '0;
   logic signed [31:0]     req_grad_in = '0;
   logic signed [31:0]     req_hess_in = '0;
   logic                   rsp_valid;
   logic signed [63:0]     rsp_grad_sum;
   logic signed [63:0]     rsp_hess_sum;
   logic                   rsp_status;
   logic                   csr_we = 1'b0;
   gha_pkg::csr_index_type csr_index = gha_pkg::CSR_FEATURE_COUNT;
   logic [12:0]            csr_wdata = '0;

   int          fail_count;
   int          pending;
   int          stall_cycles = 0;
   int          idle_pct = 0;
   int          fc_lim = gha_pkg::MAX_FEATURES_DEF;
   int          tb_lim = gha_pkg::MAX_BINS_DEF;
   logic [11:0] offset_shadow [gha_pkg::MAX_FEATURES_DEF] = '{default: '0};
   logic [11:0] hot_bins[$];

   int phase_fc    [NUM_PHASES] = '{256, 7, 511, 1, 0, 40};
   int phase_tb    [NUM_PHASES] = '{4096, 300, 8191, 1, 0, 1000};
   int phase_idle  [NUM_PHASES] = '{0, 73, 0, 22, 73, 22};
   int phase_items [NUM_PHASES] = '{120, 100, 110, 40, 20, 120};

   always #10 clock = ~clock;

   gradient_histogram_accumulator_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_feature      (req_feature),
      .req_local_bin    (req_local_bin),
      .req_offset_value (req_offset_value),
      .req_read_bin     (req_read_bin),
      .req_grad_in      (req_grad_in),
      .req_hess_in      (req_hess_in),
      .rsp_valid        (rsp_valid),
      .rsp_grad_sum     (rsp_grad_sum),
      .rsp_hess_sum     (rsp_hess_sum),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   bin_sum_checker u_bin_sum_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_feature      (req_feature),
      .req_local_bin    (req_local_bin),
      .req_offset_value (req_offset_value),
      .req_read_bin     (req_read_bin),
      .req_grad_in      (req_grad_in),
      .req_hess_in      (req_hess_in),
      .rsp_valid        (rsp_valid),
      .rsp_grad_sum     (rsp_grad_sum),
      .rsp_hess_sum     (rsp_hess_sum),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // clearing pass after reset is the longest legal quiet stretch
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5, 0))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0;
         3:       return 32'hffff_ffff;
         4:       return $urandom_range(255, 0);
         default: return $urandom;
      endcase
   endfunction

   // Presents one beat, holds it until it is taken and returns once busy drops; may idle afterwards.
   task automatic send_item(input gha_pkg::opcode_type op, input logic [7:0] feat,
                            input logic [7:0] lbin, input logic [11:0] offv,
                            input logic [11:0] rbin, input logic [31:0] g,
                            input logic [31:0] h);
      int gbin;
      case (op)
         gha_pkg::OP_WRITE_OFFSET: if (int'(feat) < fc_lim) offset_shadow[feat] = offv;
         gha_pkg::OP_ACCUMULATE: begin
            gbin = int'(offset_shadow[feat]) + int'(lbin);
            if (int'(feat) < fc_lim && gbin < tb_lim) begin
               hot_bins = {hot_bins, 12'(gbin)};
               if (hot_bins.size() > 16) void'(hot_bins.pop_front());
            end
         end
         default: ;
      endcase
      start            <= 1'b1;
      req_opcode       <= op;
      req_feature      <= feat;
      req_local_bin    <= lbin;
      req_offset_value <= offv;
      req_read_bin     <= rbin;
      req_grad_in      <= g;
      req_hess_in      <= h;
      @(posedge clock);
      while (busy) @(posedge clock);
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_random_item();
      gha_pkg::opcode_type op;
      logic [7:0]          feat;
      logic [7:0]          lbin;
      logic [11:0]         offv;
      logic [11:0]         rbin;
      int                  pick;
      feat = 8'($urandom);
      lbin = 8'($urandom);
      offv = 12'($urandom);
      rbin = 12'($urandom);
      pick = $urandom_range(99, 0);
      if (pick < 10) op = gha_pkg::OP_WRITE_OFFSET;
      else if (pick < 62) op = gha_pkg::OP_ACCUMULATE;
      else if (pick < 88) op = gha_pkg::OP_READ;
      else op = gha_pkg::OP_READ_CLEAR;
      // mostly valid features and a few hot bins so sums build up and get read back
      if (fc_lim > 0 && $urandom_range(99, 0) < 85) feat = 8'($urandom_range(fc_lim - 1, 0));
      if ($urandom_range(99, 0) < 70) lbin = 8'($urandom_range(7, 0));
      if (tb_lim > 0 && $urandom_range(99, 0) < 85) offv = 12'($urandom_range(tb_lim - 1, 0));
      if (hot_bins.size() > 0 && $urandom_range(99, 0) < 70)
         rbin = hot_bins[$urandom_range(hot_bins.size() - 1, 0)];
      send_item(op, feat, lbin, offv, rbin, rand_word(), rand_word());
   endtask

   // Drains every outstanding result, then lets the pipeline go quiet.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input gha_pkg::csr_index_type idx, input logic [12:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input int fc, input int tb);
      write_csr(gha_pkg::CSR_FEATURE_COUNT, 13'(fc));
      write_csr(gha_pkg::CSR_TOTAL_BINS, 13'(tb));
      fc_lim = (fc < gha_pkg::MAX_FEATURES_DEF) ? fc : gha_pkg::MAX_FEATURES_DEF;
      tb_lim = (tb < gha_pkg::MAX_BINS_DEF) ? tb : gha_pkg::MAX_BINS_DEF;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset limits: full feature and bin range
      send_item(gha_pkg::OP_READ, 8'd0, 8'd0, 12'd0, 12'd0, rand_word(), rand_word());
      send_item(gha_pkg::OP_WRITE_OFFSET, 8'd255, 8'd0, 12'd4095, 12'd0, 32'd0, 32'd0);
      send_item(gha_pkg::OP_WRITE_OFFSET, 8'd1, 8'd0, 12'd4000, 12'd0, 32'd0, 32'd0);
      send_item(gha_pkg::OP_ACCUMULATE, 8'd0, 8'd0, 12'd0, 12'd0, 32'h7fff_ffff,
                32'h8000_0000);
      send_item(gha_pkg::OP_ACCUMULATE, 8'd0, 8'd0, 12'd0, 12'd0, 32'h8000_0000,
                32'h7fff_ffff);
      send_item(gha_pkg::OP_ACCUMULATE, 8'd0, 8'd255, 12'd0, 12'd0, 32'hffff_ffff, 32'd1);
      send_item(gha_pkg::OP_ACCUMULATE, 8'd255, 8'd0, 12'd0, 12'd0, 32'd5, 32'd6);
      send_item(gha_pkg::OP_ACCUMULATE, 8'd255, 8'd1, 12'd0, 12'd0, 32'd7, 32'd8);
      send_item(gha_pkg::OP_ACCUMULATE, 8'd1, 8'd95, 12'd0, 12'd0, 32'hffff_fff0, 32'd3);
      send_item(gha_pkg::OP_ACCUMULATE, 8'd1, 8'd96, 12'd0, 12'd0, 32'd9, 32'd9);
      send_item(gha_pkg::OP_READ, 8'd0, 8'd0, 12'd0, 12'd0, 32'd0, 32'd0);
      send_item(gha_pkg::OP_READ_CLEAR, 8'd0, 8'd0, 12'd0, 12'd0, 32'd0, 32'd0);
      send_item(gha_pkg::OP_READ, 8'd0, 8'd0, 12'd0, 12'd0, 32'd0, 32'd0);
      send_item(gha_pkg::OP_READ_CLEAR, 8'd0, 8'd0, 12'd0, 12'd4095, 32'd0, 32'd0);
      send_item(gha_pkg::OP_READ, 8'd0, 8'd0, 12'd0, 12'd255, 32'd0, 32'd0);

      // narrow limits: feature and bin range errors
      settle();
      set_limits(3, 300);
      send_item(gha_pkg::OP_WRITE_OFFSET, 8'd3, 8'd0, 12'd10, 12'd0, 32'd0, 32'd0);
      send_item(gha_pkg::OP_ACCUMULATE, 8'd200, 8'd0, 12'd0, 12'd0, 32'd1, 32'd1);
      send_item(gha_pkg::OP_ACCUMULATE, 8'd0, 8'd0, 12'd0, 12'd0, 32'd11, 32'd12);
      send_item(gha_pkg::OP_READ, 8'd0, 8'd0, 12'd0, 12'd299, 32'd0, 32'd0);
      send_item(gha_pkg::OP_READ, 8'd0, 8'd0, 12'd0, 12'd300, 32'd0, 32'd0);
      send_item(gha_pkg::OP_READ_CLEAR, 8'd0, 8'd0, 12'd0, 12'd4095, 32'd0, 32'd0);

      // zero registers: every item is out of range
      settle();
      set_limits(0, 0);
      send_item(gha_pkg::OP_ACCUMULATE, 8'd0, 8'd0, 12'd0, 12'd0, 32'd1, 32'd1);
      send_item(gha_pkg::OP_READ, 8'd0, 8'd0, 12'd0, 12'd0, 32'd0, 32'd0);
      send_item(gha_pkg::OP_WRITE_OFFSET, 8'd0, 8'd0, 12'd5, 12'd0, 32'd0, 32'd0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         set_limits(phase_fc[p], phase_tb[p]);
         idle_pct = phase_idle[p];
         repeat (phase_items[p]) send_random_item();
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/gha_pkg.sv
hw/rtl/gha_offset_table.sv
hw/rtl/gha_bin_store.sv
hw/rtl/gradient_histogram_accumulator_top.sv
hw/rtl/gha_checker.sv
dv/bin_sum_checker.sv
dv/tb_top.sv
